@@ rtl/core/playfair_digraph_cipher_core_macros.svh @@
// assertion helpers for the playfair core
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_MACROS_SVH

// property that must hold on every cycle out of reset
`define PFC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define PFC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/pfc_pkg.sv @@
`default_nettype none
package pfc_pkg;

  localparam int NumLetters = 26;
  localparam int Side       = 5;
  localparam int Cells      = 25;

  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterZ = 5'd25;
  localparam logic [2:0] SideLast = 3'd4;
  localparam logic [2:0] RowFull  = 3'd5;

  typedef enum logic [1:0] {
    MODE_KEY     = 2'd0,
    MODE_FINISH  = 2'd1,
    MODE_ENCRYPT = 2'd2,
    MODE_CLEAR   = 2'd3
  } pfc_mode_t;

  typedef enum logic [2:0] {
    ST_ENC       = 3'd0,
    ST_ADDED     = 3'd1,
    ST_SKIPPED   = 3'd2,
    ST_COMPLETE  = 3'd3,
    ST_NOT_READY = 3'd4,
    ST_CLEARED   = 3'd5
  } pfc_status_t;

  typedef struct packed {
    logic        load;
    logic        key_step;
    logic        fill_start;
    logic        fill_step;
    logic        clear;
    logic        res_load;
    logic        cipher_load;
    pfc_status_t res_status;
    logic        out_load;
  } pfc_cmd_t;

  typedef struct packed {
    pfc_mode_t mode;
    logic      ready;
    logic      key_ok;
    logic      fill_last;
    logic      out_free;
  } pfc_stat_t;

  // saturate to z, then read j as i
  function automatic logic [4:0] plain_letter(input logic [4:0] x);
    logic [4:0] y;
    y = (x > LetterZ) ? LetterZ : x;
    if (y == LetterJ) begin
      y = LetterI;
    end
    return y;
  endfunction

  function automatic logic [2:0] inc_mod5(input logic [2:0] v);
    return (v == SideLast) ? 3'd0 : v + 3'd1;
  endfunction

  // row * 5 + col
  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/pfc_ram.sv @@
`default_nettype none
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ rtl/core/pfc_ctrl.sv @@
`default_nettype none
module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pfc_stat_t stat,
  output pfc_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_ENC_CELL,
    S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.res_status  = ST_ENC;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_KEY: begin
            cmd.key_step   = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = stat.key_ok ? ST_ADDED : ST_SKIPPED;
            state_next     = S_EMIT;
          end
          MODE_FINISH: begin
            if (stat.ready) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_COMPLETE;
              state_next     = S_EMIT;
            end else begin
              cmd.fill_start = 1'b1;
              state_next     = S_FILL;
            end
          end
          MODE_ENCRYPT: begin
            if (stat.ready) begin
              // square read issued this cycle from the looked-up places
              state_next = S_ENC_CELL;
            end else begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_NOT_READY;
              state_next     = S_EMIT;
            end
          end
          default: begin
            cmd.clear      = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_CLEARED;
            state_next     = S_EMIT;
          end
        endcase
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_COMPLETE;
          state_next     = S_EMIT;
        end
      end
      S_ENC_CELL: begin
        cmd.res_load    = 1'b1;
        cmd.cipher_load = 1'b1;
        cmd.res_status  = ST_ENC;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pfc_datapath.sv @@
`default_nettype none
module pfc_datapath
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pfc_cmd_t   cmd,
  output pfc_stat_t       stat,
  input  wire logic [1:0] mode,
  input  wire logic [4:0] letter_a,
  input  wire logic [4:0] letter_b,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [4:0] cipher_a,
  output logic      [4:0] cipher_b,
  output logic      [2:0] status
);

  `include "playfair_digraph_cipher_core_macros.svh"

  pfc_mode_t             mode_q;
  logic [4:0]            key_q;
  logic [NumLetters-1:0] seen;
  logic [2:0]            fill_row;
  logic [2:0]            fill_col;
  logic                  square_ready;
  logic [4:0]            fill_k;
  logic [4:0]            res_a;
  logic [4:0]            res_b;
  pfc_status_t           res_st;

  logic       full;
  logic       key_seen;
  logic       key_ok;
  logic       fill_ok;
  logic       wr_en;
  logic [4:0] wr_letter;
  logic [4:0] fill_addr;
  logic [5:0] place_a;
  logic [5:0] place_b;
  logic [2:0] ra, xa, rb, xb;
  logic [2:0] ra_n, xa_n, rb_n, xb_n;
  logic [4:0] sq_raddr_a;
  logic [4:0] sq_raddr_b;
  logic [4:0] sq_rdata_a;
  logic [4:0] sq_rdata_b;

  assign full      = (fill_row == RowFull);
  assign fill_addr = cell_addr(fill_row, fill_col);
  assign key_seen  = (key_q <= LetterZ) ? seen[key_q] : 1'b1;
  assign key_ok    = !square_ready && (key_q != LetterJ) && !key_seen && !full;
  assign fill_ok   = (fill_k != LetterJ) && !seen[fill_k] && !full;
  assign wr_en     = (cmd.key_step && key_ok) || (cmd.fill_step && fill_ok);
  assign wr_letter = cmd.fill_step ? fill_k : key_q;

  assign stat.mode      = mode_q;
  assign stat.ready     = square_ready;
  assign stat.key_ok    = key_ok;
  assign stat.fill_last = (fill_k == LetterZ);
  assign stat.out_free  = !out_valid || out_ready;

  // place store holds {row, col} of each placed letter
  pfc_ram #(
    .WIDTH (6),
    .DEPTH (NumLetters)
  ) u_place_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_letter),
    .wdata   ({fill_row, fill_col}),
    .raddr_a (plain_letter(letter_a)),
    .raddr_b (plain_letter(letter_b)),
    .rdata_a (place_a),
    .rdata_b (place_b)
  );

  assign ra = place_a[5:3];
  assign xa = place_a[2:0];
  assign rb = place_b[5:3];
  assign xb = place_b[2:0];

  // identical letters fall into the same-row rule
  always_comb begin
    if (ra == rb) begin
      ra_n = ra;
      xa_n = inc_mod5(xa);
      rb_n = rb;
      xb_n = inc_mod5(xb);
    end else if (xa == xb) begin
      ra_n = inc_mod5(ra);
      xa_n = xa;
      rb_n = inc_mod5(rb);
      xb_n = xb;
    end else begin
      ra_n = ra;
      xa_n = xb;
      rb_n = rb;
      xb_n = xa;
    end
  end

  assign sq_raddr_a = cell_addr(ra_n, xa_n);
  assign sq_raddr_b = cell_addr(rb_n, xb_n);

  pfc_ram #(
    .WIDTH (5),
    .DEPTH (Cells)
  ) u_square_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (fill_addr),
    .wdata   (wr_letter),
    .raddr_a (sq_raddr_a),
    .raddr_b (sq_raddr_b),
    .rdata_a (sq_rdata_a),
    .rdata_b (sq_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seen         <= '0;
      fill_row     <= 3'd0;
      fill_col     <= 3'd0;
      square_ready <= 1'b0;
      fill_k       <= 5'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        seen         <= '0;
        fill_row     <= 3'd0;
        fill_col     <= 3'd0;
        square_ready <= 1'b0;
      end else begin
        if (wr_en) begin
          seen[wr_letter] <= 1'b1;
          if (fill_col == SideLast) begin
            fill_col <= 3'd0;
            fill_row <= fill_row + 3'd1;
          end else begin
            fill_col <= fill_col + 3'd1;
          end
        end
        if (cmd.fill_step && stat.fill_last) begin
          square_ready <= 1'b1;
        end
      end
      if (cmd.fill_start) begin
        fill_k <= 5'd0;
      end else if (cmd.fill_step) begin
        fill_k <= fill_k + 5'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= pfc_mode_t'(mode);
      key_q  <= letter_a;
    end
    if (cmd.res_load) begin
      res_st <= cmd.res_status;
      res_a  <= cmd.cipher_load ? sq_rdata_a : 5'd0;
      res_b  <= cmd.cipher_load ? sq_rdata_b : 5'd0;
    end
    if (cmd.out_load) begin
      cipher_a <= res_a;
      cipher_b <= res_b;
      status   <= res_st;
    end
  end

  `PFC_ASSERT_ALWAYS(a_seen_matches_fill, clk, rst, $countones(seen) == int'(fill_addr), "seen count differs from fill count")
  `PFC_ASSERT_IMPLY(a_ready_full, clk, rst, square_ready, full && !seen[LetterJ], "ready square not full")
  `PFC_ASSERT_IMPLY(a_no_write_ready, clk, rst, wr_en, !square_ready, "square written after finish")
  `PFC_ASSERT_IMPLY(a_out_no_overrun, clk, rst, cmd.out_load, stat.out_free, "result overwrote pending word")

endmodule
`default_nettype wire

@@ rtl/core/playfair_digraph_cipher_core.sv @@
// key, clear and refused items pass the decode and emit states before out_valid;
// a pair passes decode, cell read and emit; a filling finish adds the fill state
// a new item is taken only in idle, once the last result has left emit; the finish walks
// all 26 letters one per cycle and each pair makes two dependent RAM reads in series
// reset clears the seen flags, fill count, ready flag and output valid flag; the square
// and place RAMs get no clearing pass and are undefined until written
`default_nettype none
module playfair_digraph_cipher_core
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [4:0] letter_a,
  input  wire logic [4:0] letter_b,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [4:0] cipher_a,
  output logic      [4:0] cipher_b,
  output logic      [2:0] status
);

  pfc_cmd_t  cmd;
  pfc_stat_t stat;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .letter_a  (letter_a),
    .letter_b  (letter_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cipher_a  (cipher_a),
    .cipher_b  (cipher_b),
    .status    (status)
  );

endmodule
`default_nettype wire
